FILE: rtl/csvft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csvft_pkg;

    // parser state codes
    localparam logic [2:0] ST_START  = 3'd0;
    localparam logic [2:0] ST_PLAIN  = 3'd1;
    localparam logic [2:0] ST_QUOTED = 3'd2;
    localparam logic [2:0] ST_QCLOSE = 3'd3;
    localparam logic [2:0] ST_AFTER  = 3'd4;
    localparam logic [2:0] ST_IGNORE = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       field_end;
        logic [4:0] column;
        logic       line_end;
        logic [5:0] field_count;
        logic       truncated;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/csvft_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One byte of parsing: next state and the result, if any.
module csvft_step
    import csvft_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 256,
    parameter int MAX_COLUMNS     = 32,
    parameter int LW              = 8,
    parameter int CW              = 5
)
(
    input  wire logic [2:0]    state,
    input  wire logic [LW-1:0] flen,
    input  wire logic [CW-1:0] col,
    input  wire logic [7:0]    ch,
    output logic [2:0]         state_next,
    output logic [LW-1:0]      flen_next,
    output logic [CW-1:0]      col_next,
    output logic               emit,
    output res_t               res
);

    localparam int EW = (CW + 1 > 6) ? CW + 1 : 6;
    localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_FIELD_BYTES - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(MAX_COLUMNS - 1);

    logic          is_quote;
    logic          is_comma;
    logic          is_nul;
    logic          col_last;
    logic [EW-1:0] col_ext;
    logic [EW-1:0] col_inc_ext;

    assign is_quote    = (ch == CH_QUOTE);
    assign is_comma    = (ch == CH_COMMA);
    assign is_nul      = (ch == CH_NUL);
    assign col_last    = (col == COL_LAST);
    assign col_ext     = EW'(col);
    assign col_inc_ext = col_ext + EW'(1);

    always_comb
    begin
        logic          do_close;
        logic          do_add;
        logic [7:0]    add_byte;
        logic [2:0]    add_stay;
        logic [LW-1:0] flen_base;
        logic [LW-1:0] flen_inc;
        logic          valid;
        logic          fend;
        logic          lend;
        logic          trunc;

        do_close   = 1'b0;
        do_add     = 1'b0;
        add_byte   = ch;
        add_stay   = ST_PLAIN;
        flen_base  = flen;
        state_next = state;
        flen_next  = flen;
        col_next   = col;
        emit       = 1'b0;
        valid      = 1'b0;
        fend       = 1'b0;
        lend       = 1'b0;
        trunc      = 1'b0;

        case (state)
            ST_PLAIN:
            begin
                if (is_comma || is_nul)
                    do_close = 1'b1;
                else
                    do_add = 1'b1;
            end
            ST_QUOTED:
            begin
                add_stay = ST_QUOTED;
                if (is_quote)
                    state_next = ST_QCLOSE;
                else if (is_nul)
                    do_close = 1'b1;
                else
                    do_add = 1'b1;
            end
            ST_QCLOSE:
            begin
                // doubled quote is a literal quote
                add_stay = ST_QUOTED;
                add_byte = CH_QUOTE;
                if (is_quote)
                    do_add = 1'b1;
                else
                    do_close = 1'b1;
            end
            ST_AFTER:
            begin
                if (is_comma && !col_last)
                begin
                    col_next   = col + CW'(1);
                    flen_next  = '0;
                    state_next = ST_START;
                end
                else
                begin
                    emit = 1'b1;
                    lend = 1'b1;
                    if (is_nul)
                    begin
                        state_next = ST_START;
                        flen_next  = '0;
                        col_next   = '0;
                    end
                    else
                        state_next = ST_IGNORE;
                end
            end
            ST_IGNORE:
            begin
                if (is_nul)
                begin
                    state_next = ST_START;
                    flen_next  = '0;
                    col_next   = '0;
                end
            end
            default:
            begin
                flen_base = '0;
                flen_next = '0;
                if (is_quote)
                    state_next = ST_QUOTED;
                else if (is_comma || is_nul)
                    do_close = 1'b1;
                else
                    do_add = 1'b1;
            end
        endcase

        if (do_close)
        begin
            emit = 1'b1;
            fend = 1'b1;
            if (is_comma)
            begin
                if (!col_last)
                begin
                    col_next   = col + CW'(1);
                    flen_next  = '0;
                    state_next = ST_START;
                end
                else
                begin
                    lend       = 1'b1;
                    state_next = ST_IGNORE;
                end
            end
            else
            begin
                lend = 1'b1;
                if (is_nul)
                begin
                    state_next = ST_START;
                    flen_next  = '0;
                    col_next   = '0;
                end
                else
                    state_next = ST_IGNORE;
            end
        end

        // flen stays below the limit, so the increment cannot wrap
        flen_inc = flen_base + LW'(1);
        if (do_add)
        begin
            emit      = 1'b1;
            valid     = 1'b1;
            flen_next = flen_inc;
            if (flen_inc == LEN_LIMIT)
            begin
                fend       = 1'b1;
                trunc      = 1'b1;
                state_next = ST_AFTER;
            end
            else
                state_next = add_stay;
        end

        res.data_byte   = valid ? add_byte : 8'h00;
        res.byte_valid  = valid;
        res.field_end   = fend;
        res.column      = col_ext[4:0];
        res.line_end    = lend;
        res.field_count = lend ? col_inc_ext[5:0] : 6'd0;
        res.truncated   = trunc;
    end

endmodule

`default_nettype wire

FILE: rtl/csv_field_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming CSV tokenizer: one byte of a line per request on ch, a zero byte ends
// the line. Field characters come out tagged with their column; field_end,
// line_end and truncated mark field and line boundaries, and field_count is
// given with line_end. Throughput is one byte per cycle unless a byte with a
// result waits on a stalled output register: a byte sits in an input register,
// one short state update decides its result, and the result is held in an
// output register. A byte that gives no result leaves even while the output
// register is stalled; a byte that gives one waits for that register.
module csv_field_tokenizer
    import csvft_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 256,
    parameter int MAX_COLUMNS     = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic            field_end,
    output logic [4:0]      column,
    output logic            line_end,
    output logic [5:0]      field_count,
    output logic            truncated
);

    localparam int LW = $clog2(MAX_FIELD_BYTES);
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    ch_reg;
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [LW-1:0] flen_reg;
    logic [LW-1:0] flen_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          res_reg;
    res_t          step_res;
    logic          step_emit;
    logic          advance;

    csvft_step #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .MAX_COLUMNS     (MAX_COLUMNS),
        .LW              (LW),
        .CW              (CW)
    ) u_step (
        .state      (state_reg),
        .flen       (flen_reg),
        .col        (col_reg),
        .ch         (ch_reg),
        .state_next (state_next),
        .flen_next  (flen_next),
        .col_next   (col_next),
        .emit       (step_emit),
        .res        (step_res)
    );

    assign advance  = in_valid_reg && (!step_emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
            in_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (advance && step_emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_START;
            flen_reg      <= '0;
            col_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                flen_reg  <= flen_next;
                col_reg   <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            ch_reg <= ch;
        if (advance && step_emit)
            res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = res_reg.data_byte;
    assign byte_valid  = res_reg.byte_valid;
    assign field_end   = res_reg.field_end;
    assign column      = res_reg.column;
    assign line_end    = res_reg.line_end;
    assign field_count = res_reg.field_count;
    assign truncated   = res_reg.truncated;

    // a length-limited close always carries the last character
    a_trunc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> field_end && byte_valid)
        else $error("truncated result without field_end and character");

    // line end never carries a character
    a_lend_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> !byte_valid)
        else $error("line_end result carries a character");

    a_count_only_at_lend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_end |-> field_count == 6'd0)
        else $error("field_count set without line_end");

    // a held byte is never dropped while waiting on the output register
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(ch_reg))
        else $error("stalled input byte lost");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import csvft_pkg::*;

    localparam int FIELD_LIMIT = 256;
    localparam int COL_LIMIT   = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 25;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       field_end;
    logic [4:0] column;
    logic       line_end;
    logic [5:0] field_count;
    logic       truncated;

    // tokenizer state mirrored in the testbench
    logic [2:0]  pstate;
    int unsigned flen;
    int unsigned col;

    res_t token_q[$];
    bit   calm = 1'b0;
    int   errors = 0;
    int   bytes_sent = 0;
    int   tokens_seen = 0;
    int   lines_seen = 0;
    int   trunc_seen = 0;
    int   stall_cycles = 0;

    csv_field_tokenizer #(
        .MAX_FIELD_BYTES(FIELD_LIMIT),
        .MAX_COLUMNS(COL_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .ch(ch),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data_byte(data_byte),
        .byte_valid(byte_valid),
        .field_end(field_end),
        .column(column),
        .line_end(line_end),
        .field_count(field_count),
        .truncated(truncated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic flag_error(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic push_token(input logic [7:0] b, input bit v, input bit fe,
                              input bit le, input bit tr);
        res_t r;
        r.data_byte   = v ? b : 8'h00;
        r.byte_valid  = v;
        r.field_end   = fe;
        r.column      = col[4:0];
        r.line_end    = le;
        r.field_count = le ? 6'(col + 1) : 6'd0;
        r.truncated   = tr;
        token_q.push_back(r);
    endtask

    task automatic restart_line();
        pstate = ST_START;
        flen   = 0;
        col    = 0;
    endtask

    task automatic end_field(input logic [7:0] c);
        if (c == CH_COMMA && col + 1 < COL_LIMIT)
        begin
            push_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            col++;
            flen   = 0;
            pstate = ST_START;
        end
        else
        begin
            // comma on the last column lands here too and ends the line
            push_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            if (c == CH_NUL)
                restart_line();
            else
                pstate = ST_IGNORE;
        end
    endtask

    task automatic append_char(input logic [7:0] c, input logic [2:0] stay);
        flen++;
        if (flen >= FIELD_LIMIT - 1)
        begin
            pstate = ST_AFTER;
            push_token(c, 1'b1, 1'b1, 1'b0, 1'b1);
        end
        else
        begin
            pstate = stay;
            push_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        case (pstate)
            ST_PLAIN:
                if (c == CH_COMMA || c == CH_NUL)
                    end_field(c);
                else
                    append_char(c, ST_PLAIN);
            ST_QUOTED:
                if (c == CH_QUOTE)
                    pstate = ST_QCLOSE;
                else if (c == CH_NUL)
                    end_field(c);
                else
                    append_char(c, ST_QUOTED);
            ST_QCLOSE:
                if (c == CH_QUOTE)
                    append_char(CH_QUOTE, ST_QUOTED);
                else
                    end_field(c);
            ST_AFTER:
                if (c == CH_COMMA && col + 1 < COL_LIMIT)
                begin
                    col++;
                    flen   = 0;
                    pstate = ST_START;
                end
                else
                begin
                    push_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
                    if (c == CH_NUL)
                        restart_line();
                    else
                        pstate = ST_IGNORE;
                end
            ST_IGNORE:
                if (c == CH_NUL)
                    restart_line();
            default:
            begin
                flen = 0;
                if (c == CH_QUOTE)
                    pstate = ST_QUOTED;
                else if (c == CH_COMMA || c == CH_NUL)
                    end_field(c);
                else
                    append_char(c, ST_PLAIN);
            end
        endcase
    endtask

    // one request on ch; valid is only dropped while idling
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tokenize_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_COMMA);
        return c;
    endfunction

    task automatic send_text(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte(text_byte());
    endtask

    task automatic send_commas(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            send_text($urandom_range(0, 2));
            send_byte(CH_COMMA);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (out_valid && out_ready)
        begin
            tokens_seen++;
            if (line_end)
                lines_seen++;
            if (truncated)
                trunc_seen++;
            if (token_q.size() == 0)
                flag_error($sformatf("unexpected result, column %0d line_end %0b",
                                     column, line_end));
            else
            begin
                want = token_q.pop_front();
                if (data_byte !== want.data_byte)
                    flag_error($sformatf("data_byte %h, expected %h",
                                         data_byte, want.data_byte));
                if (byte_valid !== want.byte_valid)
                    flag_error($sformatf("byte_valid %b, expected %b",
                                         byte_valid, want.byte_valid));
                if (field_end !== want.field_end)
                    flag_error($sformatf("field_end %b, expected %b",
                                         field_end, want.field_end));
                if (column !== want.column)
                    flag_error($sformatf("column %0d, expected %0d",
                                         column, want.column));
                if (line_end !== want.line_end)
                    flag_error($sformatf("line_end %b, expected %b",
                                         line_end, want.line_end));
                if (field_count !== want.field_count)
                    flag_error($sformatf("field_count %0d, expected %0d",
                                         field_count, want.field_count));
                if (truncated !== want.truncated)
                    flag_error($sformatf("truncated %b, expected %b",
                                         truncated, want.truncated));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // plain field, empty fields, empty line, zero ending a plain field
    task automatic test_field_basics();
        send_byte("a");
        send_byte(CH_COMMA);
        send_byte(CH_COMMA);
        send_byte(CH_NUL);
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CH_NUL);
    endtask

    // opening quote, doubled quote, comma inside quotes, close then comma, close then text
    task automatic test_quoting();
        send_byte(CH_QUOTE);
        send_byte("x");
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(CH_COMMA);
        send_byte(CH_QUOTE);
        send_byte(CH_COMMA);
        send_byte(CH_QUOTE);
        send_byte(CH_COMMA);
        send_byte(CH_QUOTE);
        send_byte(8'h80);
        send_byte(CH_NUL);
    endtask

    // text after a closing quote ends the line; the rest is dropped
    task automatic test_line_tail();
        send_byte(CH_QUOTE);
        send_byte("b");
        send_byte(CH_QUOTE);
        send_byte("z");
        send_byte(8'hFF);
        send_byte(CH_COMMA);
        send_byte(CH_QUOTE);
        send_byte(CH_NUL);
    endtask

    task automatic test_truncation();
        int i;
        // one short of the limit, then a limit-length plain field and a comma
        send_text(FIELD_LIMIT - 2);
        send_byte(CH_COMMA);
        send_text(FIELD_LIMIT - 1);
        send_byte(CH_COMMA);
        // quoted field hitting the limit, then text: line end only
        send_byte(CH_QUOTE);
        for (i = 0; i < FIELD_LIMIT - 1; i++)
            if ($urandom_range(9) == 0)
            begin
                send_byte(CH_QUOTE);
                send_byte(CH_QUOTE);
            end
            else
                send_byte(text_byte());
        send_byte("x");
        send_byte(CH_NUL);
        // truncated field followed straight by the zero byte
        send_text(FIELD_LIMIT - 1);
        send_byte(CH_NUL);
    endtask

    task automatic test_column_limit();
        send_commas(COL_LIMIT - 1);
        send_text(2);
        send_byte(CH_COMMA);
        send_byte(text_byte());
        send_byte(CH_COMMA);
        send_byte(CH_NUL);

        // quoted last column closed by a comma
        send_commas(COL_LIMIT - 1);
        send_byte(CH_QUOTE);
        send_byte("q");
        send_byte(CH_QUOTE);
        send_byte(CH_COMMA);
        send_byte(CH_NUL);

        send_commas(COL_LIMIT - 1);
        send_byte("y");
        send_byte(CH_NUL);

        // truncated last column, comma cannot open another one
        send_commas(COL_LIMIT - 1);
        send_text(FIELD_LIMIT - 1);
        send_byte(CH_COMMA);
        send_byte(CH_NUL);
    endtask

    task automatic send_record();
        int nf;
        int i;
        int j;
        int len;
        nf = ($urandom_range(19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
        for (i = 0; i < nf; i++)
        begin
            if (i != 0)
                send_byte(CH_COMMA);
            len = ($urandom_range(39) == 0) ? $urandom_range(250, 258) : $urandom_range(0, 6);
            if ($urandom_range(9) < 4)
            begin
                send_byte(CH_QUOTE);
                for (j = 0; j < len; j++)
                    case ($urandom_range(9))
                        0:
                        begin
                            send_byte(CH_QUOTE);
                            send_byte(CH_QUOTE);
                        end
                        1: send_byte(CH_COMMA);
                        default: send_byte(text_byte());
                    endcase
                send_byte(CH_QUOTE);
            end
            else
                send_text(len);
        end
        send_byte(CH_NUL);
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
            case ($urandom_range(5))
                0: send_byte(CH_QUOTE);
                1: send_byte(CH_COMMA);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        send_byte(CH_NUL);
    endtask

    task automatic test_random_lines(input int target);
        int first;
        int done;
        first = bytes_sent;
        done  = 0;
        while (done < target)
        begin
            // a stretch in the middle runs with no idling on either side
            calm = (done >= target / 4) && (done < 3 * target / 4);
            if ($urandom_range(99) < 80)
                send_record();
            else
                send_noise();
            done = bytes_sent - first;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        restart_line();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_basics();
        test_quoting();
        test_line_tail();
        test_truncation();
        test_column_limit();
        test_random_lines(250);

        in_valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes covering quoting, empty and truncated fields, column limit.",
                 bytes_sent);
        $display("Checked %0d results: %0d line ends, %0d truncations, %0d mismatches.",
                 tokens_seen, lines_seen, trunc_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
